### rtl/pcc_pkg.sv
// Package for the polygon coplanarity check block.
// Holds widths, the sequencer state type and the shared-unit control struct.
package pcc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NORM_WIDTH  = FRAC_BITS + 2;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int CROSS_WIDTH = 2 * DIFF_WIDTH + 1;
    localparam int DOT_WIDTH   = NORM_WIDTH + DIFF_WIDTH + 2;
    localparam int CNT_WIDTH   = 16;
    localparam int TOL_WIDTH   = 32;
    localparam int V_WIDTH     = 31;
    localparam int SUMSQ_WIDTH = 64;
    localparam int ROOT_WIDTH  = 32;
    localparam int QUO_WIDTH   = V_WIDTH + FRAC_BITS + 1;
    localparam int MAG_WIDTH   = CROSS_WIDTH - 1;
    localparam int LEN_WIDTH   = $clog2(MAG_WIDTH + 1);
    localparam int ROOT_STEPS  = SUMSQ_WIDTH / 2;
    localparam int STEP_WIDTH  = $clog2(QUO_WIDTH + 1);

    localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_NORM,
        ST_SUMSQ,
        ST_ROOT,
        ST_DIV,
        ST_DOT,
        ST_DONE
    } pcc_state_t;

    typedef struct packed {
        logic [1:0] sel_a;
        logic [1:0] sel_b;
        logic       negate;
        logic       clear;
    } pcc_mul_ctrl_t;

endpackage

### rtl/pcc_mac.sv
// Shared signed multiply-accumulate unit for the coplanarity check.
// Depends on pcc_pkg; one product is added to or subtracted from the registered accumulator each cycle that en is high.
module pcc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcc_pkg::pcc_mul_ctrl_t              ctrl,
    input  logic                                en,
    input  logic signed [pcc_pkg::DIFF_WIDTH:0] op_a,
    input  logic signed [pcc_pkg::DIFF_WIDTH:0] op_b,
    output logic signed [pcc_pkg::CROSS_WIDTH+1:0] acc
);
    import pcc_pkg::*;

    logic signed [2*DIFF_WIDTH+1:0] prod;
    logic signed [CROSS_WIDTH+1:0]  acc_reg;
    logic signed [CROSS_WIDTH+1:0]  acc_next;

    assign prod = op_a * op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (en)
        begin
            if (ctrl.clear)
            begin
                acc_next = '0;
            end
            if (ctrl.negate)
            begin
                acc_next = acc_next - (CROSS_WIDTH+2)'(prod);
            end
            else
            begin
                acc_next = acc_next + (CROSS_WIDTH+2)'(prod);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

### rtl/pcc_isqrt_div.sv
// Iterative square root and restoring divider for the normal calculation.
// Depends on pcc_pkg; one root step or one quotient bit per cycle.
module pcc_isqrt_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              root_start,
    input  logic [pcc_pkg::SUMSQ_WIDTH-1:0]   radicand,
    input  logic                              div_start,
    input  logic [pcc_pkg::V_WIDTH-1:0]       dividend,
    output logic                              busy,
    output logic [pcc_pkg::ROOT_WIDTH-1:0]    root,
    output logic [pcc_pkg::NORM_WIDTH-1:0]    quotient
);
    import pcc_pkg::*;

    localparam int NUM_WIDTH = V_WIDTH + FRAC_BITS + 1;

    logic                     mode_reg, mode_next;
    logic                     busy_reg, busy_next;
    logic [STEP_WIDTH-1:0]    step_reg, step_next;
    logic [SUMSQ_WIDTH-1:0]   x_reg, x_next;
    logic [SUMSQ_WIDTH-1:0]   res_reg, res_next;
    logic [SUMSQ_WIDTH-1:0]   bit_reg, bit_next;
    logic [NUM_WIDTH-1:0]     num_reg, num_next;
    logic [ROOT_WIDTH:0]      rem_reg, rem_next;
    logic [NUM_WIDTH-1:0]     q_reg, q_next;
    logic [ROOT_WIDTH:0]      trial;
    logic [SUMSQ_WIDTH-1:0]   rb;

    always_comb
    begin
        mode_next = mode_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        rb        = res_reg + bit_reg;
        trial     = {rem_reg[ROOT_WIDTH-1:0], num_reg[NUM_WIDTH-1]};
        if (root_start)
        begin
            mode_next = 1'b0;
            busy_next = 1'b1;
            step_next = STEP_WIDTH'(ROOT_STEPS);
            x_next    = radicand;
            res_next  = '0;
            bit_next  = SUMSQ_WIDTH'(1) << (SUMSQ_WIDTH - 2);
        end
        else if (div_start)
        begin
            mode_next = 1'b1;
            busy_next = 1'b1;
            step_next = STEP_WIDTH'(NUM_WIDTH);
            num_next  = NUM_WIDTH'({dividend, {FRAC_BITS{1'b0}}})
                        + NUM_WIDTH'(res_reg[ROOT_WIDTH-1:1]);
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_WIDTH'(1))
            begin
                busy_next = 1'b0;
            end
            if (!mode_reg)
            begin
                if (x_reg >= rb)
                begin
                    x_next   = x_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                num_next = num_reg << 1;
                if (trial >= {1'b0, res_reg[ROOT_WIDTH-1:0]})
                begin
                    rem_next = trial - {1'b0, res_reg[ROOT_WIDTH-1:0]};
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[NUM_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mode_reg <= mode_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign root     = res_reg[ROOT_WIDTH-1:0];
    assign quotient = q_reg[NORM_WIDTH-1:0];
endmodule

### rtl/polygon_coplanarity_check_core.sv
// Top level of the polygon coplanarity check.
// Depends on pcc_pkg, pcc_mac and pcc_isqrt_div.
//
// Vertices enter on the input channel (px, py, pz, last_vertex) under
// in_valid/in_stall. A word is taken when in_valid is high and in_stall is
// low. A result word (coplanar, vertex_total) leaves under out_valid/
// out_stall only on a vertex flagged as the last of its polygon.
// The first two vertices are stored. The third vertex builds the plane
// normal: six products through the one shared multiplier (one per cycle),
// a scan for the largest magnitude, three squares, a 32-step square root
// and three divisions of 48 steps each in the bit-serial root and divide
// unit. Every later vertex takes three products through the same
// multiplier and a compare.
// A result word is loaded into the output register once the last vertex
// has finished its own work. While the receiver stalls it waits there;
// the block keeps taking vertices and only holds at the end of the next
// polygon until the register has been emptied.
// Reset clears the count, the failure flag, the first two stored points and
// the normal, and sets the tolerance register to one LSB.
module polygon_coplanarity_check_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcc_pkg::TOL_WIDTH-1:0]       cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pcc_pkg::COORD_WIDTH-1:0] px,
    input  logic signed [pcc_pkg::COORD_WIDTH-1:0] py,
    input  logic signed [pcc_pkg::COORD_WIDTH-1:0] pz,
    input  logic                                last_vertex,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                coplanar,
    output logic [pcc_pkg::CNT_WIDTH-1:0]       vertex_total
);
    import pcc_pkg::*;

    pcc_state_t state_reg, state_next;

    logic [TOL_WIDTH-1:0]                tol_reg;
    logic signed [COORD_WIDTH-1:0]       org_reg [3];
    logic signed [COORD_WIDTH-1:0]       sec_reg [3];
    logic signed [COORD_WIDTH-1:0]       pt_reg [3];
    logic signed [NORM_WIDTH-1:0]        nrm_reg [3];
    logic signed [CROSS_WIDTH+1:0]       cr_reg [3];
    logic [V_WIDTH-1:0]                  v_reg [3];
    logic [CNT_WIDTH-1:0]                cnt_reg;
    logic                                off_reg;
    logic                                last_reg;
    logic [2:0]                          step_reg, step_next;
    logic [LEN_WIDTH-1:0]                len_reg;
    logic [SUMSQ_WIDTH-1:0]              ssq_reg;
    logic                                ov_reg;
    logic                                cop_reg;
    logic [CNT_WIDTH-1:0]                tot_reg;
    logic                                unit_wait_reg;

    logic                                accept;
    logic                                out_fire;
    logic                                result_load;
    logic [CNT_WIDTH-1:0]                cnt_inc;
    pcc_mul_ctrl_t                       mctl;
    logic                                men;
    logic signed [DIFF_WIDTH:0]          ma, mb;
    logic signed [CROSS_WIDTH+1:0]       acc;
    logic signed [DIFF_WIDTH:0]          da [3];
    logic signed [DIFF_WIDTH:0]          db [3];
    logic signed [DIFF_WIDTH:0]          nx [3];
    logic [MAG_WIDTH-1:0]                mag [3];
    logic [MAG_WIDTH-1:0]                mag_or;
    logic [LEN_WIDTH-1:0]                len_c;
    logic [V_WIDTH-1:0]                  vsh [3];
    logic [DOT_WIDTH-1:0]                dot_abs;
    logic                                root_start, div_start, ud_busy;
    logic [ROOT_WIDTH-1:0]               root;
    logic [NORM_WIDTH-1:0]               quo;
    logic [V_WIDTH-1:0]                  sq_op;
    logic [2*V_WIDTH-1:0]                vsq;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // A result loads once the output register is empty or is emptied now.
    assign result_load = (state_reg == ST_DONE) && last_reg && (!ov_reg || out_fire);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            da[i] = (DIFF_WIDTH+1)'(sec_reg[i]) - (DIFF_WIDTH+1)'(org_reg[i]);
            db[i] = (DIFF_WIDTH+1)'(pt_reg[i]) - (DIFF_WIDTH+1)'(org_reg[i]);
            nx[i] = (DIFF_WIDTH+1)'(nrm_reg[i]);
            mag[i] = cr_reg[i][CROSS_WIDTH+1] ? MAG_WIDTH'(-cr_reg[i])
                                              : MAG_WIDTH'(cr_reg[i]);
        end
    end

    // Length of the largest cross-product magnitude; magnitudes scaled by it.
    always_comb
    begin
        mag_or = mag[0] | mag[1] | mag[2];
        len_c  = '0;
        for (int k = 0; k < MAG_WIDTH; k++)
        begin
            if (mag_or[k])
            begin
                len_c = LEN_WIDTH'(k + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > LEN_WIDTH'(V_WIDTH))
            begin
                vsh[i] = V_WIDTH'(mag[i] >> (len_reg - LEN_WIDTH'(V_WIDTH)));
            end
            else
            begin
                vsh[i] = V_WIDTH'(mag[i] << (LEN_WIDTH'(V_WIDTH) - len_reg));
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mctl = '0;
        men  = 1'b0;
        ma   = '0;
        mb   = '0;
        if (state_reg == ST_CROSS)
        begin
            men         = 1'b1;
            mctl.clear  = !step_reg[0];
            mctl.negate = step_reg[0];
            unique case (step_reg)
                3'd0: begin ma = da[1]; mb = db[2]; end
                3'd1: begin ma = da[2]; mb = db[1]; end
                3'd2: begin ma = da[2]; mb = db[0]; end
                3'd3: begin ma = da[0]; mb = db[2]; end
                3'd4: begin ma = da[0]; mb = db[1]; end
                default: begin ma = da[1]; mb = db[0]; end
            endcase
        end
        else if (state_reg == ST_DOT && step_reg < 3'd3)
        begin
            men        = 1'b1;
            mctl.clear = (step_reg == 3'd0);
            unique case (step_reg)
                3'd0: begin ma = nx[0]; mb = db[0]; end
                3'd1: begin ma = nx[1]; mb = db[1]; end
                default: begin ma = nx[2]; mb = db[2]; end
            endcase
        end
    end

    pcc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mctl),
        .en    (men),
        .op_a  (ma),
        .op_b  (mb),
        .acc   (acc)
    );

    // Steps one to three of the sum of squares take the three components in turn.
    always_comb
    begin
        unique case (step_reg)
            3'd2:    sq_op = v_reg[1];
            3'd3:    sq_op = v_reg[2];
            default: sq_op = v_reg[0];
        endcase
    end

    assign root_start = (state_reg == ST_SUMSQ) && (step_reg == 3'd4);
    assign div_start  = (state_reg == ST_DIV) && !unit_wait_reg && !ud_busy;
    assign vsq        = sq_op * sq_op;

    pcc_isqrt_div u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_start (root_start),
        .radicand   (ssq_reg),
        .div_start  (div_start),
        .dividend   (v_reg[step_reg[1:0]]),
        .busy       (ud_busy),
        .root       (root),
        .quotient   (quo)
    );

    assign dot_abs = acc[CROSS_WIDTH+1] ? DOT_WIDTH'(-acc) : DOT_WIDTH'(acc);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (cnt_inc == CNT_WIDTH'(3))
                    begin
                        state_next = ST_CROSS;
                    end
                    else if (cnt_inc > CNT_WIDTH'(3))
                    begin
                        state_next = ST_DOT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CROSS:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd6)
                begin
                    state_next = ST_NORM;
                    step_next  = '0;
                end
            end
            ST_NORM:
            begin
                state_next = (len_c == '0) ? ST_DONE : ST_SUMSQ;
            end
            ST_SUMSQ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                begin
                    state_next = ST_ROOT;
                    step_next  = '0;
                end
            end
            ST_ROOT:
            begin
                if (!ud_busy && !root_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (unit_wait_reg && !ud_busy)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == 3'd2)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // A finished polygon waits here while the previous result is stalled.
                if (!last_reg || result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tol_reg       <= TOL_WIDTH'(1);
            cnt_reg       <= '0;
            off_reg       <= 1'b0;
            ov_reg        <= 1'b0;
            cop_reg       <= 1'b0;
            tot_reg       <= '0;
            unit_wait_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                sec_reg[i] <= '0;
                nrm_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cnt_reg <= cnt_inc;
                if (cnt_inc == CNT_WIDTH'(1))
                begin
                    org_reg <= '{px, py, pz};
                end
                if (cnt_inc == CNT_WIDTH'(2))
                begin
                    sec_reg <= '{px, py, pz};
                end
            end
            if (state_reg == ST_NORM && len_c == '0)
            begin
                nrm_reg <= '{'0, '0, '0};
            end
            if (state_reg == ST_DIV)
            begin
                if (div_start)
                begin
                    unit_wait_reg <= 1'b1;
                end
                else if (unit_wait_reg && !ud_busy)
                begin
                    unit_wait_reg <= 1'b0;
                    nrm_reg[step_reg[1:0]] <= cr_reg[step_reg[1:0]][CROSS_WIDTH+1]
                        ? -$signed(quo) : $signed(quo);
                end
            end
            if (state_reg == ST_DOT && step_reg == 3'd3)
            begin
                if (dot_abs > DOT_WIDTH'({tol_reg, {FRAC_BITS{1'b0}}}))
                begin
                    off_reg <= 1'b1;
                end
            end
            if (result_load)
            begin
                ov_reg  <= 1'b1;
                cop_reg <= !off_reg;
                tot_reg <= cnt_reg;
                cnt_reg <= '0;
                off_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg   <= '{px, py, pz};
            last_reg <= last_vertex;
        end
        // The accumulator shows a finished component in the cycle after its
        // second product, so components land at steps two, four and six.
        if (state_reg == ST_CROSS && !step_reg[0] && step_reg != 3'd0)
        begin
            cr_reg[step_reg[2:1] - 2'd1] <= acc;
        end
        if (state_reg == ST_NORM)
        begin
            len_reg <= len_c;
        end
        if (state_reg == ST_SUMSQ)
        begin
            if (step_reg == 3'd0)
            begin
                v_reg   <= vsh;
                ssq_reg <= '0;
            end
            else
            begin
                v_reg   <= v_reg;
            end
        end
        if (state_reg == ST_SUMSQ && step_reg != 3'd0 && step_reg != 3'd4)
        begin
            ssq_reg <= ssq_reg + SUMSQ_WIDTH'(vsq);
        end
    end

    assign out_valid    = ov_reg;
    assign coplanar     = cop_reg;
    assign vertex_total = tot_reg;

`ifndef SYNTHESIS
    a_unit_idle_in_dot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DOT |-> !ud_busy) else $error("root unit busy during a dot");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_total) && $stable(coplanar))
        else $error("result changed under stall");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && (!last_reg || result_load) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle");
`endif
endmodule
